// ===== sv/tpjq_pkg.sv =====
package tpjq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_TIERS   = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIER_W      = 2;
  localparam int STORE_DEPTH = NUM_TIERS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int MODE_W  = 2;
  localparam int ID_W    = 16;
  localparam int PAGES_W = 8;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = ID_W + PAGES_W;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0]  CFG_SMALL_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  CFG_MEDIUM_LIMIT  = CFG_IDX_W'(1);
  localparam logic [PAGES_W-1:0]    SMALL_LIMIT_RST   = PAGES_W'(11);
  localparam logic [PAGES_W-1:0]    MEDIUM_LIMIT_RST  = PAGES_W'(21);

  // Request modes (mode three decodes as peek)
  localparam logic [MODE_W-1:0] MODE_SUBMIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

  // Tier codes
  localparam logic [TIER_W-1:0] TIER_SMALL  = 2'd0;
  localparam logic [TIER_W-1:0] TIER_MEDIUM = 2'd1;
  localparam logic [TIER_W-1:0] TIER_LARGE  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    job_id;
    logic [PAGES_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic               job_valid;
    logic [ID_W-1:0]    out_job_id;
    logic [PAGES_W-1:0] out_page_count;
    logic [TIER_W-1:0]  out_tier;
    logic [STAT_W-1:0]  status;
  } rsp_t;

  // Decision taken at accept; id and pages come from the store when use_ram is set
  typedef struct packed {
    logic use_ram;
    rsp_t rsp;
  } acc_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // Circular pointer step
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

endpackage

// ===== sv/tpjq_ram.sv =====
module tpjq_ram #(
  parameter int Width = 24,
  parameter int Depth = 48,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tpjq_ctrl.sv =====
module tpjq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  tpjq_pkg::req_t                   req_i,
  input  logic [tpjq_pkg::PAGES_W-1:0]     small_limit_i,
  input  logic [tpjq_pkg::PAGES_W-1:0]     medium_limit_i,
  output logic                             ram_we_o,
  output logic [tpjq_pkg::ADDR_W-1:0]      ram_waddr_o,
  output logic [tpjq_pkg::ENTRY_W-1:0]     ram_wdata_o,
  output logic                             ram_re_o,
  output logic [tpjq_pkg::ADDR_W-1:0]      ram_raddr_o,
  output tpjq_pkg::acc_t                   acc_o
);

  localparam int NT = tpjq_pkg::NUM_TIERS;
  localparam int PW = tpjq_pkg::PTR_W;
  localparam int CW = tpjq_pkg::CNT_W;
  localparam int AW = tpjq_pkg::ADDR_W;

  logic [NT-1:0][PW-1:0] head_q, head_d;
  logic [NT-1:0][PW-1:0] tail_q, tail_d;
  logic [NT-1:0][CW-1:0] cnt_q, cnt_d;

  logic                        is_submit, is_take;
  logic [tpjq_pkg::TIER_W-1:0] sub_tier, pick_tier;
  logic                        sub_full, found;
  logic                        ptr_ok, cnt_ok;

  // Decode, classify and pick the highest-priority non-empty tier
  always_comb begin
    is_submit = (req_i.mode == tpjq_pkg::MODE_SUBMIT);
    is_take   = (req_i.mode == tpjq_pkg::MODE_TAKE);

    if (req_i.page_count < small_limit_i) begin
      sub_tier = tpjq_pkg::TIER_SMALL;
    end else if (req_i.page_count < medium_limit_i) begin
      sub_tier = tpjq_pkg::TIER_MEDIUM;
    end else begin
      sub_tier = tpjq_pkg::TIER_LARGE;
    end
    sub_full = (cnt_q[sub_tier] == CW'(tpjq_pkg::QUEUE_DEPTH));

    found     = 1'b0;
    pick_tier = tpjq_pkg::TIER_SMALL;
    for (int t = NT - 1; t >= 0; t--) begin
      if (cnt_q[t] != '0) begin
        found     = 1'b1;
        pick_tier = tpjq_pkg::TIER_W'(t);
      end
    end
  end

  // Store access: tail write on submit, head read on take or peek
  always_comb begin
    ram_we_o    = accept_i && is_submit && !sub_full;
    ram_waddr_o = AW'(sub_tier) * AW'(tpjq_pkg::QUEUE_DEPTH) + AW'(tail_q[sub_tier]);
    ram_wdata_o = {req_i.job_id, req_i.page_count};
    ram_re_o    = accept_i && !is_submit && found;
    ram_raddr_o = AW'(pick_tier) * AW'(tpjq_pkg::QUEUE_DEPTH) + AW'(head_q[pick_tier]);
  end

  // Result decision
  always_comb begin
    acc_o = '0;
    if (is_submit) begin
      acc_o.rsp.job_valid      = !sub_full;
      acc_o.rsp.out_job_id     = req_i.job_id;
      acc_o.rsp.out_page_count = req_i.page_count;
      acc_o.rsp.out_tier       = sub_tier;
      acc_o.rsp.status         = sub_full ? tpjq_pkg::STAT_DROPPED : tpjq_pkg::STAT_OK;
    end else if (found) begin
      acc_o.use_ram       = 1'b1;
      acc_o.rsp.job_valid = 1'b1;
      acc_o.rsp.out_tier  = pick_tier;
      acc_o.rsp.status    = tpjq_pkg::STAT_OK;
    end else begin
      acc_o.rsp.status = tpjq_pkg::STAT_EMPTY;
    end
  end

  // Pointer and fill count update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (accept_i && is_submit && !sub_full) begin
      tail_d[sub_tier] = tpjq_pkg::ptr_advance(tail_q[sub_tier]);
      cnt_d[sub_tier]  = cnt_q[sub_tier] + CW'(1);
    end
    if (accept_i && is_take && found) begin
      head_d[pick_tier] = tpjq_pkg::ptr_advance(head_q[pick_tier]);
      cnt_d[pick_tier]  = cnt_q[pick_tier] - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Checks: counts bounded, empty or full tiers have coinciding pointers
  always_comb begin
    ptr_ok = 1'b1;
    cnt_ok = 1'b1;
    for (int t = 0; t < NT; t++) begin
      if (cnt_q[t] > CW'(tpjq_pkg::QUEUE_DEPTH)) begin
        cnt_ok = 1'b0;
      end
      if ((cnt_q[t] == '0 || cnt_q[t] == CW'(tpjq_pkg::QUEUE_DEPTH)) &&
          head_q[t] != tail_q[t]) begin
        ptr_ok = 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_ok)
    else $error("tier fill count above queue depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni) ptr_ok)
    else $error("head and tail disagree for empty or full tier");

  a_drop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_submit && sub_full |=> $stable(cnt_q) && $stable(tail_q))
    else $error("dropped submit changed queue state");

  a_take_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_take && found |=> cnt_q != $past(cnt_q))
    else $error("take did not remove a job");

endmodule

// ===== sv/tiered_priority_job_queue_core.sv =====
// Flow: an accepted request's decision is registered and the block enters its busy state, where the result
// waits on the registered read of the job store RAM and is loaded into the output register once that register
// is empty or being taken. No new request is accepted until the previous result has been loaded there.
// A new request is taken while the previous result still waits on the output.
// Reset: tier pointers and fill counts clear, limits return to 11 and 21, no result pending;
// the job store itself is not cleared.
module tiered_priority_job_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tpjq_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tpjq_pkg::rsp_t                    out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpjq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tpjq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tpjq_pkg::state_e state_q, state_d;

  logic                         accept, out_load;
  logic [tpjq_pkg::PAGES_W-1:0] small_limit_q, medium_limit_q;
  tpjq_pkg::acc_t               acc, hold_q;
  tpjq_pkg::rsp_t               rsp_busy, out_rsp_q;
  logic                         out_valid_q;

  logic                          ram_we, ram_re;
  logic [tpjq_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [tpjq_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // Limit registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_limit_q  <= tpjq_pkg::SMALL_LIMIT_RST;
      medium_limit_q <= tpjq_pkg::MEDIUM_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tpjq_pkg::CFG_SMALL_LIMIT) begin
        small_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == tpjq_pkg::CFG_MEDIUM_LIMIT) begin
        medium_limit_q <= cfg_data_i;
      end
    end
  end

  // Queue bookkeeping
  tpjq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_i         (in_req_i),
    .small_limit_i (small_limit_q),
    .medium_limit_i(medium_limit_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .acc_o         (acc)
  );

  // Job store, all tiers in one RAM
  tpjq_ram #(
    .Width(tpjq_pkg::ENTRY_W),
    .Depth(tpjq_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpjq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tpjq_pkg::ST_BUSY;
        end
      end
      tpjq_pkg::ST_BUSY: begin
        if (out_load) begin
          state_d = tpjq_pkg::ST_IDLE;
        end
      end
      default: state_d = tpjq_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tpjq_pkg::ST_IDLE: in_ready_o = 1'b1;
      tpjq_pkg::ST_BUSY: out_load = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpjq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decision held for the read cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= acc;
    end
  end

  // Merge read data into the result
  always_comb begin
    rsp_busy = hold_q.rsp;
    if (hold_q.use_ram) begin
      rsp_busy.out_job_id     = ram_rdata[tpjq_pkg::ENTRY_W-1:tpjq_pkg::PAGES_W];
      rsp_busy.out_page_count = ram_rdata[tpjq_pkg::PAGES_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= rsp_busy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == tpjq_pkg::ST_BUSY)
    else $error("accepted request did not enter read cycle");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == tpjq_pkg::ST_IDLE)
    else $error("result not loaded into output register");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tpjq_pkg::ST_BUSY && !out_load |=> state_q == tpjq_pkg::ST_BUSY)
    else $error("pending result lost");

endmodule

// ===== bench/tiered_priority_job_queue_core_tb.sv =====
module tiered_priority_job_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpjq_pkg::*;

  // Mode three has no name in the package; the block decodes it like peek
  localparam logic [MODE_W-1:0] MODE_PEEK_ALIAS = 2'd3;
  // Register indexes outside the map, written to check that they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_IDX_W'(8'hFE);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(8'h02);

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int PHASE_ITEMS      = 110;
  localparam int NUM_PHASES       = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_req;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shared between the stimulus and the receiver; the current limits are used by the stimulus only
  bit hold_request;
  int idle_odds;
  logic [PAGES_W-1:0] cur_small;
  logic [PAGES_W-1:0] cur_medium;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PAGES_W-1:0] pages;
  } queued_job_t;

  // Tier queues mirrored in software, plus the results they imply
  class job_queue_scoreboard;
    queued_job_t        tier_fifo[NUM_TIERS][$];
    rsp_t               expected_q[$];
    logic [PAGES_W-1:0] small_limit;
    logic [PAGES_W-1:0] medium_limit;
    int                 errors;

    function new();
      small_limit  = SMALL_LIMIT_RST;
      medium_limit = MEDIUM_LIMIT_RST;
      errors       = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SMALL_LIMIT) begin
        small_limit = data;
      end else if (idx == CFG_MEDIUM_LIMIT) begin
        medium_limit = data;
      end
    endfunction

    // Tier 0 test first, limits applied as written even when out of order
    function logic [TIER_W-1:0] tier_of(logic [PAGES_W-1:0] pages);
      if (pages < small_limit) return TIER_SMALL;
      if (pages < medium_limit) return TIER_MEDIUM;
      return TIER_LARGE;
    endfunction

    function void note_request(req_t r);
      rsp_t              e;
      logic [TIER_W-1:0] t;
      queued_job_t       j;
      bit                found;
      e = '0;
      found = 1'b0;
      if (r.mode == MODE_SUBMIT) begin
        t = tier_of(r.page_count);
        e.out_job_id     = r.job_id;
        e.out_page_count = r.page_count;
        e.out_tier       = t;
        if (tier_fifo[t].size() >= QUEUE_DEPTH) begin
          e.job_valid = 1'b0;
          e.status    = STAT_DROPPED;
        end else begin
          j.id    = r.job_id;
          j.pages = r.page_count;
          tier_fifo[t].push_back(j);
          e.job_valid = 1'b1;
          e.status    = STAT_OK;
        end
      end else begin
        // take, peek and the peek alias: strict priority over the tiers
        e.status = STAT_EMPTY;
        for (int i = 0; i < NUM_TIERS; i++) begin
          if (!found && tier_fifo[i].size() != 0) begin
            found = 1'b1;
            j = tier_fifo[i][0];
            e.job_valid      = 1'b1;
            e.out_job_id     = j.id;
            e.out_page_count = j.pages;
            e.out_tier       = TIER_W'(i);
            e.status         = STAT_OK;
            if (r.mode == MODE_TAKE) void'(tier_fifo[i].pop_front());
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("job_valid", 32'(e.job_valid), 32'(got.job_valid));
      compare_field("out_job_id", 32'(e.out_job_id), 32'(got.out_job_id));
      compare_field("out_page_count", 32'(e.out_page_count), 32'(got.out_page_count));
      compare_field("out_tier", 32'(e.out_tier), 32'(got.out_tier));
      compare_field("status", 32'(e.status), 32'(got.status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  job_queue_scoreboard sb;

  tiered_priority_job_queue_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transaction monitor: everything sampled as it stood at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_req);
      if (out_valid && out_ready) sb.check_result(out_rsp);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_index, cfg_data);
    end
  end

  // Watchdog on cycles without any transaction
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random back-pressure bursts, one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic req_t make_req(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                    logic [PAGES_W-1:0] pages);
    req_t r;
    r.mode       = mode;
    r.job_id     = id;
    r.page_count = pages;
    return r;
  endfunction

  function automatic int next_gap();
    if (idle_odds == 0) return 0;
    if ($urandom_range(0, idle_odds - 1) == 0) return $urandom_range(1, 5);
    return 0;
  endfunction

  // Page counts cluster on the tier boundaries of the current limits
  function automatic logic [PAGES_W-1:0] pick_pages();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return cur_small - 8'd1;
      3: return cur_small;
      4: return cur_medium - 8'd1;
      5: return cur_medium;
      default: return PAGES_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Called right after an edge; valid stays high between back-to-back requests
  task automatic drive_req(req_t r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [PAGES_W-1:0] small_v, logic [PAGES_W-1:0] medium_v);
    write_cfg(CFG_SMALL_LIMIT, small_v);
    write_cfg(CFG_MEDIUM_LIMIT, medium_v);
    cur_small  = small_v;
    cur_medium = medium_v;
  endtask

  // Submit bursts to one tier (to reach full), take bursts (to reach empty), and noise
  task automatic random_phase(int n_items);
    int                 sent;
    int                 kind;
    int                 len;
    logic [PAGES_W-1:0] burst_pages;
    req_t               r;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(3, 20);
      burst_pages = pick_pages();
      for (int k = 0; k < len; k++) begin
        r.job_id = ID_W'($urandom_range(0, 65535));
        if (kind < 5) begin
          r.mode = MODE_SUBMIT;
          r.page_count = ($urandom_range(0, 7) == 0) ? pick_pages() : burst_pages;
        end else if (kind < 8) begin
          r.mode = ($urandom_range(0, 5) == 0) ? MODE_PEEK : MODE_TAKE;
          r.page_count = PAGES_W'($urandom_range(0, 255));
        end else begin
          r.mode = MODE_W'($urandom_range(0, 3));
          r.page_count = pick_pages();
        end
        drive_req(r, next_gap());
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [PAGES_W-1:0] lim_small[NUM_PHASES];
    logic [PAGES_W-1:0] lim_medium[NUM_PHASES];
    sb = new();
    hold_request = 1'b0;
    idle_odds    = 6;
    cur_small    = SMALL_LIMIT_RST;
    cur_medium   = MEDIUM_LIMIT_RST;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queues, tier boundaries at reset limits, priority order
    drive_req(make_req(MODE_TAKE, 16'h1234, 8'd5), next_gap());
    drive_req(make_req(MODE_PEEK, 16'hFFFF, 8'hFF), next_gap());
    drive_req(make_req(MODE_PEEK_ALIAS, 16'h0000, 8'h00), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'hFFFF, 8'd255), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h0000, 8'd0), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h00A1, 8'd21), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h00A2, 8'd20), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h00A3, 8'd11), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h00A4, 8'd10), next_gap());
    drive_req(make_req(MODE_SUBMIT, 16'h5A5A, 8'd1), next_gap());
    drive_req(make_req(MODE_PEEK, 16'hAAAA, 8'hAA), next_gap());
    drive_req(make_req(MODE_PEEK_ALIAS, 16'h5555, 8'h55), next_gap());
    repeat (8) drive_req(make_req(MODE_TAKE, 16'hFFFF, 8'hFF), next_gap());
    drain();

    lim_small  = '{8'd0, 8'd255, 8'd200, 8'd1, 8'd0, 8'd0, 8'd0, 8'd11};
    lim_medium = '{8'd0, 8'd255, 8'd50, 8'd2, 8'd255, 8'd0, 8'd0, 8'd21};
    lim_small[5]  = PAGES_W'($urandom_range(1, 255));
    lim_medium[5] = PAGES_W'($urandom_range(1, 255));
    lim_small[6]  = PAGES_W'($urandom_range(0, 255));
    lim_medium[6] = PAGES_W'($urandom_range(0, 255));

    for (int p = 0; p < NUM_PHASES; p++) begin
      // no idling in the last phase, and some phases without idling at all
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      if (p == NUM_PHASES - 1) idle_odds = 0;
      set_limits(lim_small[p], lim_medium[p]);
      if (p == 6) begin
        write_cfg(CFG_UNMAPPED_HI, CFG_DATA_W'($urandom_range(0, 255)));
        write_cfg(CFG_UNMAPPED_LO, CFG_DATA_W'($urandom_range(0, 255)));
      end
      // long receiver hold while the sender keeps offering
      if (p == 2) hold_request = 1'b1;
      random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== tiered_priority_job_queue_core.f =====
sv/tpjq_pkg.sv
sv/tpjq_ram.sv
sv/tpjq_ctrl.sv
sv/tiered_priority_job_queue_core.sv
bench/tiered_priority_job_queue_core_tb.sv
